FILE: src/nta_pkg.sv
// ----------------------------------------------------------------------------
// nta_pkg
// Shared widths, character codes and helpers for the binary to ASCII field
// formatter and its port checker.
// ----------------------------------------------------------------------------
package nta_pkg;

    localparam int VALUE_W            = 32;
    localparam int LEN_W              = 4;
    localparam int CHAR_W             = 7;
    localparam int NUM_BCD            = 10;  // decimal digits of a 32-bit value
    localparam int BCD_W              = 4 * NUM_BCD;
    localparam int BIT_CNT_W          = $clog2(VALUE_W);
    localparam int DIG_IDX_W          = $clog2(NUM_BCD);
    localparam int DEFAULT_MAX_DIGITS = 10;

    localparam logic [CHAR_W-1:0] CH_SPACE = 7'd32;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CH_NINE  = 7'd57;
    localparam logic [CHAR_W-1:0] CH_ALPHA = 7'd65;
    localparam logic [CHAR_W-1:0] CH_HEX_F = 7'd70;

    localparam logic CMD_DEC = 1'b0;
    localparam logic CMD_HEX = 1'b1;

    // ASCII code of one digit: '0'-'9', then 'A'-'F'
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] dig);
        logic [CHAR_W-1:0] code;
        if (dig < 4'd10) begin
            code = CH_ZERO + {3'b000, dig};
        end else begin
            code = CH_ALPHA + {3'b000, dig - 4'd10};
        end
        return code;
    endfunction

    // double-dabble correction of one BCD digit before the next shift
    function automatic logic [3:0] bcd_adjust(input logic [3:0] dig);
        logic [3:0] adj;
        if (dig >= 4'd5) begin
            adj = dig + 4'd3;
        end else begin
            adj = dig;
        end
        return adj;
    endfunction

endpackage

FILE: src/number_to_ascii_digits.sv
// ----------------------------------------------------------------------------
// number_to_ascii_digits
// Formats a 32-bit unsigned word as a fixed-width decimal or hex ASCII field.
// ----------------------------------------------------------------------------
// Decimal conversion shifts in one bit per cycle with shift-add-3
// correction, hex needs none; then a scan walks the digits from the top,
// one per cycle, and emits the low field_length of them.
// A new word is taken only in idle, once conversion and scan are done.
// Reset clears the control state; the receiver cannot stall the results.
module number_to_ascii_digits #(
    parameter int MAX_DIGITS = nta_pkg::DEFAULT_MAX_DIGITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_cmd,
    input  logic [nta_pkg::VALUE_W-1:0]  i_value,
    input  logic [nta_pkg::LEN_W-1:0]    i_field_length,
    input  logic                         i_leading_zero,
    output logic                         o_strobe,
    output logic [nta_pkg::CHAR_W-1:0]   o_char_code,
    output logic                         o_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    localparam logic [nta_pkg::LEN_W-1:0] MAX_LEN = nta_pkg::LEN_W'(MAX_DIGITS);
    localparam logic [nta_pkg::DIG_IDX_W-1:0] TOP_IDX =
        nta_pkg::DIG_IDX_W'(nta_pkg::NUM_BCD - 1);

    logic [1:0]                          r_state, n_state;
    logic [nta_pkg::VALUE_W-1:0]         r_sh, n_sh;
    logic [nta_pkg::BCD_W-1:0]           r_bcd, n_bcd;
    logic [nta_pkg::BIT_CNT_W-1:0]       r_cnt, n_cnt;
    logic [nta_pkg::DIG_IDX_W-1:0]       r_idx, n_idx;
    logic                                r_nz, n_nz;
    logic [nta_pkg::LEN_W-1:0]           r_len, n_len;
    logic                                r_hex, n_hex;
    logic                                r_pad, n_pad;
    logic                                r_strobe, n_strobe;
    logic [nta_pkg::CHAR_W-1:0]          r_char, n_char;
    logic                                r_last, n_last;

    logic [nta_pkg::BCD_W-1:0]           adj_bcd;
    logic [3:0]                          top_dig;
    logic                                nz_now;

    always_comb begin
        for (int i = 0; i < nta_pkg::NUM_BCD; i++) begin
            adj_bcd[4*i +: 4] = nta_pkg::bcd_adjust(r_bcd[4*i +: 4]);
        end
    end

    assign top_dig = r_bcd[nta_pkg::BCD_W-1 -: 4];
    assign nz_now  = r_nz | (top_dig != 4'd0);

    always_comb begin
        n_state  = r_state;
        n_sh     = r_sh;
        n_bcd    = r_bcd;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_nz     = r_nz;
        n_len    = r_len;
        n_hex    = r_hex;
        n_pad    = r_pad;
        n_strobe = 1'b0;
        n_char   = r_char;
        n_last   = r_last;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_hex = (i_cmd == nta_pkg::CMD_HEX);
                    n_pad = i_leading_zero;
                    n_len = (i_field_length > MAX_LEN) ? MAX_LEN : i_field_length;
                    n_idx = TOP_IDX;
                    n_nz  = 1'b0;
                    n_sh  = i_value;
                    n_cnt = nta_pkg::BIT_CNT_W'(nta_pkg::VALUE_W - 1);
                    if (i_cmd == nta_pkg::CMD_HEX) begin
                        n_bcd   = nta_pkg::BCD_W'(i_value);
                        n_state = ST_SCAN;
                    end else begin
                        n_bcd   = '0;
                        n_state = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                // adjust, then shift in the next bit, msb first
                n_bcd = {adj_bcd[nta_pkg::BCD_W-2:0], r_sh[nta_pkg::VALUE_W-1]};
                n_sh  = {r_sh[nta_pkg::VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // drop digits above the field, emit the rest
                if (nta_pkg::LEN_W'(r_idx) < r_len) begin
                    n_strobe = 1'b1;
                    n_last   = (r_idx == '0);
                    if (!r_hex && !r_pad && !nz_now && r_idx != '0) begin
                        n_char = nta_pkg::CH_SPACE;
                    end else begin
                        n_char = nta_pkg::digit_char(top_dig);
                    end
                end
                n_bcd = {r_bcd[nta_pkg::BCD_W-5:0], 4'b0000};
                n_nz  = nz_now;
                n_idx = r_idx - 1'b1;
                if (r_idx == '0) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh   <= n_sh;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_idx  <= n_idx;
        r_nz   <= n_nz;
        r_len  <= n_len;
        r_hex  <= n_hex;
        r_pad  <= n_pad;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_strobe    = r_strobe;
    assign o_char_code = r_char;
    assign o_last      = r_last;

endmodule

FILE: src/nta_checker.sv
// ----------------------------------------------------------------------------
// nta_checker
// Port-level checks for the ASCII field formatter, bound to its top level.
// ----------------------------------------------------------------------------
module nta_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_strobe,
    input logic [nta_pkg::CHAR_W-1:0]  o_char_code,
    input logic                        o_last
);

    // every emitted word is a space, a decimal digit or an uppercase hex digit
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_char_code == nta_pkg::CH_SPACE) ||
                     (o_char_code >= nta_pkg::CH_ZERO && o_char_code <= nta_pkg::CH_NINE) ||
                     (o_char_code >= nta_pkg::CH_ALPHA && o_char_code <= nta_pkg::CH_HEX_F))
        else $error("character out of set");

    // a word that is not the last comes while the command is still running
    a_busy_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> busy)
        else $error("character after command ended");

    // the last character closes the field: nothing follows at once
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("character right after last");

    // a new command shows no character in its first cycle
    a_start_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_strobe))
        else $error("accepted command not running");

endmodule

bind number_to_ascii_digits nta_checker u_nta_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_char_code (o_char_code),
    .o_last      (o_last)
);

FILE: tb/number_to_ascii_digits_tb.sv
// ----------------------------------------------------------------------------
// number_to_ascii_digits_tb
// Drives words into the ASCII field formatter and checks every character it
// emits. A directed table comes first: rows with an obvious answer carry
// their characters inline, and the rest are formatted by a local
// decimal/hex field builder. Random bursts with random gaps follow.
// ----------------------------------------------------------------------------
module number_to_ascii_digits_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIGITS   = nta_pkg::DEFAULT_MAX_DIGITS;
    localparam int NUM_DIRECTED = 21;
    localparam int NUM_RANDOM   = 260;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [nta_pkg::CHAR_W-1:0] code;
        logic                       last;
    } t_field_char;

    typedef struct packed {
        logic                        cmd;
        logic [nta_pkg::VALUE_W-1:0] value;
        logic [nta_pkg::LEN_W-1:0]   len;
        logic                        lz;
        logic                        typed;
        logic [8*10-1:0]             text;  // right-aligned, leftmost character highest
    } t_field_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic                        i_cmd;
    logic [nta_pkg::VALUE_W-1:0] i_value;
    logic [nta_pkg::LEN_W-1:0]   i_field_length;
    logic                        i_leading_zero;
    logic                        o_strobe;
    logic [nta_pkg::CHAR_W-1:0]  o_char_code;
    logic                        o_last;

    t_field_char pending_chars[$];
    t_field_row  directed_rows[NUM_DIRECTED];
    int          mismatches;
    int          cycle_count;

    number_to_ascii_digits #(
        .MAX_DIGITS(MAX_DIGITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_value        (i_value),
        .i_field_length (i_field_length),
        .i_leading_zero (i_leading_zero),
        .o_strobe       (o_strobe),
        .o_char_code    (o_char_code),
        .o_last         (o_last)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int clip_length(input logic [nta_pkg::LEN_W-1:0] len);
        return (int'(len) > MAX_DIGITS) ? MAX_DIGITS : int'(len);
    endfunction

    // build the field right to left, then queue it left to right
    task automatic format_field(input logic cmd, input logic [nta_pkg::VALUE_W-1:0] value,
                                input logic [nta_pkg::LEN_W-1:0] len, input logic lz);
        logic [nta_pkg::CHAR_W-1:0]  chars[MAX_DIGITS];
        logic [nta_pkg::VALUE_W-1:0] rest;
        logic [3:0]                  nib;
        int                          n;
        n    = clip_length(len);
        rest = value;
        for (int pos = n - 1; pos >= 0; pos--) begin
            if (cmd == nta_pkg::CMD_HEX) begin
                nib = rest[3:0];
                if (nib < 4'd10) begin
                    chars[pos] = nta_pkg::CH_ZERO + nta_pkg::CHAR_W'(nib);
                end else begin
                    chars[pos] = nta_pkg::CH_ALPHA + nta_pkg::CHAR_W'(nib)
                                 - nta_pkg::CHAR_W'(10);
                end
                rest = rest >> 4;
            end else begin
                nib = 4'(rest % 10);
                // blank every position but the units once nothing is left
                if (rest == '0 && !lz && pos != n - 1) begin
                    chars[pos] = nta_pkg::CH_SPACE;
                end else begin
                    chars[pos] = nta_pkg::CH_ZERO + nta_pkg::CHAR_W'(nib);
                end
                rest = rest / 10;
            end
        end
        for (int k = 0; k < n; k++) begin
            pending_chars.push_back('{code: chars[k], last: (k == n - 1)});
        end
    endtask

    task automatic queue_text(input logic [8*10-1:0] text, input int n);
        for (int k = 0; k < n; k++) begin
            pending_chars.push_back('{code: text[8*(n-1-k) +: nta_pkg::CHAR_W],
                                      last: (k == n - 1)});
        end
    endtask

    // present one word and hold it until the block takes it
    task automatic send_word(input t_field_row row);
        start          <= 1'b1;
        i_cmd          <= row.cmd;
        i_value        <= row.value;
        i_field_length <= row.len;
        i_leading_zero <= row.lz;
        do begin
            @(posedge i_clk);
        end while (busy);
        if (row.typed) begin
            queue_text(row.text, clip_length(row.len));
        end else begin
            format_field(row.cmd, row.value, row.len, row.lz);
        end
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_all_chars();
        start <= 1'b0;
        while (pending_chars.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [nta_pkg::VALUE_W-1:0] random_value();
        logic [nta_pkg::VALUE_W-1:0] v;
        int                          k;
        case ($urandom_range(0, 5))
            0: v = $urandom();
            1: v = $urandom_range(0, 99);
            2: v = $urandom_range(0, 99999);
            3: begin
                // decade edges: 10^k and 10^k - 1
                v = 1;
                k = $urandom_range(0, 9);
                repeat (k) v = v * 10;
                if ($urandom_range(0, 1) == 1) begin
                    v = v - 1;
                end
            end
            4: begin
                case ($urandom_range(0, 3))
                    0: v = '0;
                    1: v = '1;
                    2: v = 32'h8000_0000;
                    default: v = 32'hFFFF_FFF0 | $urandom_range(0, 15);
                endcase
            end
            default: v = $urandom() >> $urandom_range(0, 31);
        endcase
        return v;
    endfunction

    function automatic t_field_row random_row();
        t_field_row row;
        row.cmd   = 1'($urandom_range(0, 1));
        row.value = random_value();
        if ($urandom_range(0, 9) == 0) begin
            row.len = nta_pkg::LEN_W'($urandom_range(0, 15));
        end else begin
            row.len = nta_pkg::LEN_W'($urandom_range(1, 10));
        end
        row.lz    = 1'($urandom_range(0, 1));
        row.typed = 1'b0;
        row.text  = '0;
        return row;
    endfunction

    // compare each emitted character against the oldest one waiting
    always @(posedge i_clk) begin
        t_field_char want;
        if (i_rst_n && o_strobe) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected word: char_code %0d last %0b",
                         $time, o_char_code, o_last);
                mismatches++;
            end else begin
                want = pending_chars.pop_front();
                if (o_char_code !== want.code) begin
                    $display("%0t: char_code mismatch: expected %0d actual %0d",
                             $time, want.code, o_char_code);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last mismatch: expected %0b actual %0b",
                             $time, want.last, o_last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int         sent;
        int         burst;
        t_field_row row;

        mismatches     = 0;
        cycle_count    = 0;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_cmd          <= nta_pkg::CMD_DEC;
        i_value        <= '0;
        i_field_length <= '0;
        i_leading_zero <= 1'b0;

        directed_rows = '{
            '{nta_pkg::CMD_DEC, 32'd0,          4'd1,  1'b0, 1'b1, 80'("0")},
            '{nta_pkg::CMD_DEC, 32'd0,          4'd5,  1'b0, 1'b1, 80'("    0")},
            '{nta_pkg::CMD_DEC, 32'd0,          4'd5,  1'b1, 1'b1, 80'("00000")},
            '{nta_pkg::CMD_DEC, 32'hFFFF_FFFF,  4'd10, 1'b0, 1'b1, 80'("4294967295")},
            '{nta_pkg::CMD_HEX, 32'hFFFF_FFFF,  4'd10, 1'b0, 1'b1, 80'("00FFFFFFFF")},
            '{nta_pkg::CMD_HEX, 32'd0,          4'd10, 1'b0, 1'b1, 80'("0000000000")},
            '{nta_pkg::CMD_DEC, 32'd123,        4'd0,  1'b0, 1'b1, 80'd0},
            '{nta_pkg::CMD_HEX, 32'd123,        4'd0,  1'b1, 1'b1, 80'd0},
            '{nta_pkg::CMD_DEC, 32'd12345,      4'd15, 1'b0, 1'b1, 80'("     12345")},
            '{nta_pkg::CMD_DEC, 32'd1234567,    4'd3,  1'b0, 1'b1, 80'("567")},
            '{nta_pkg::CMD_HEX, 32'hDEAD_BEEF,  4'd4,  1'b0, 1'b1, 80'("BEEF")},
            '{nta_pkg::CMD_HEX, 32'h89AB_CDEF,  4'd11, 1'b1, 1'b1, 80'("0089ABCDEF")},
            '{nta_pkg::CMD_DEC, 32'd100,        4'd6,  1'b0, 1'b1, 80'("   100")},
            '{nta_pkg::CMD_DEC, 32'd7,          4'd8,  1'b1, 1'b1, 80'("00000007")},
            '{nta_pkg::CMD_DEC, 32'd1000000000, 4'd10, 1'b0, 1'b1, 80'("1000000000")},
            '{nta_pkg::CMD_DEC, 32'd42,         4'd12, 1'b1, 1'b1, 80'("0000000042")},
            '{nta_pkg::CMD_HEX, 32'h1234_5678,  4'd8,  1'b0, 1'b1, 80'("12345678")},
            '{nta_pkg::CMD_DEC, 32'h8000_0001,  4'd10, 1'b1, 1'b0, 80'd0},
            '{nta_pkg::CMD_DEC, 32'd5,          4'd1,  1'b1, 1'b1, 80'("5")},
            '{nta_pkg::CMD_HEX, 32'h0000_00A5,  4'd1,  1'b0, 1'b1, 80'("5")},
            '{nta_pkg::CMD_DEC, 32'd9,          4'd14, 1'b0, 1'b1, 80'("         9")}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            send_word(directed_rows[r]);
            if ($urandom_range(0, 2) == 0) begin
                idle_cycles($urandom_range(1, 30));
            end
        end

        // let the directed words finish before the random bursts
        wait_all_chars();

        sent = 0;
        while (sent < NUM_RANDOM) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                row = random_row();
                send_word(row);
                sent++;
            end
            case ($urandom_range(0, 7))
                0: wait_all_chars();
                1, 2: ;  // run straight into the next burst
                default: idle_cycles($urandom_range(1, 60));
            endcase
        end

        wait_all_chars();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_chars.size() != 0) begin
            $display("%0t: %0d characters never arrived", $time, pending_chars.size());
            mismatches++;
        end

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
src/nta_pkg.sv
src/number_to_ascii_digits.sv
src/nta_checker.sv
tb/number_to_ascii_digits_tb.sv
